### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

### rtl/core/ogrc_pkg.sv
// Shared constants, types and control structs of the occupancy grid ray clear block.
package ogrc_pkg;

	// Grid store geometry
	localparam int GRID_COLS  = 128;
	localparam int GRID_ROWS  = 128;
	localparam int GRID_DEPTH = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W     = $clog2(GRID_DEPTH);

	// Field and register widths
	localparam int KIND_W  = 2;
	localparam int COORD_W = 7;
	localparam int CELL_W  = 8;
	localparam int CFG_W   = 8;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int REGI_W  = PADDR_W - 2;

	// Datapath widths
	localparam int IDX_W = COORD_W + CFG_W + 1;
	localparam int SQ_W  = 2 * COORD_W;
	localparam int D2_W  = SQ_W + 1;
	localparam int LA_W  = CFG_W + COORD_W;
	localparam int LIM_W = 2 * LA_W;
	localparam int ERR_W = COORD_W + 1;

	// Largest usable column and row counts that an 8-bit register can name
	localparam logic [CFG_W-1:0] COL_CAP = CFG_W'((GRID_COLS > 255) ? 255 : GRID_COLS);
	localparam logic [CFG_W-1:0] ROW_CAP = CFG_W'((GRID_ROWS > 255) ? 255 : GRID_ROWS);

	// Command kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_TRACE = 2'd1,
		KIND_MARK  = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	// Register indexes
	typedef enum logic [REGI_W-1:0] {
		REG_ROW_CELLS = 3'd0,
		REG_ROW_COUNT = 3'd1,
		REG_DEFAULT   = 3'd2,
		REG_FREE      = 3'd3,
		REG_LETHAL    = 3'd4,
		REG_MAX_TRACE = 3'd5
	} reg_idx_t;

	// Grid write source
	typedef enum logic [1:0] {
		WR_NONE   = 2'd0,
		WR_CLEAR  = 2'd1,
		WR_FREE   = 2'd2,
		WR_LETHAL = 2'd3
	} wr_sel_t;

	typedef struct packed {
		logic [CFG_W-1:0] row_cells;
		logic [CFG_W-1:0] row_count;
		logic [CFG_W-1:0] clear_value;
		logic [CFG_W-1:0] free_value;
		logic [CFG_W-1:0] lethal_value;
		logic [CFG_W-1:0] max_trace_cells;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;
		logic    setup_delta;
		logic    setup_mult;
		logic    setup_walk;
		logic    walk;
		logic    clr_step;
		wr_sel_t wr_sel;
		logic    rd_en;
		logic    take_read;
		logic    load_out;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  range_ok;
		logic  walk_more;
		logic  clr_last;
	} dp_stat_t;

endpackage

### rtl/core/ogrc_if.sv
// Request and result channel interfaces.
interface ogrc_cmd_if import ogrc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;

	modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface ogrc_res_if import ogrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] read_value;
	logic              status;

	modport source (output valid, read_value, status, input ready);
	modport sink (input valid, read_value, status, output ready);
endinterface

### rtl/core/ogrc_ram.sv
// Generic single-port RAM with registered read data.
module ogrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write or read one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/ogrc_regs.sv
// APB configuration register file.
module ogrc_regs import ogrc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_cells       <= 8'd128;
			cfg_q.row_count       <= 8'd128;
			cfg_q.clear_value     <= 8'd255;
			cfg_q.free_value      <= 8'd0;
			cfg_q.lethal_value    <= 8'd254;
			cfg_q.max_trace_cells <= 8'd255;
		end else if (wr) begin
			unique case (idx)
				REG_ROW_CELLS: cfg_q.row_cells       <= pwdata[CFG_W-1:0];
				REG_ROW_COUNT: cfg_q.row_count       <= pwdata[CFG_W-1:0];
				REG_DEFAULT:   cfg_q.clear_value     <= pwdata[CFG_W-1:0];
				REG_FREE:      cfg_q.free_value      <= pwdata[CFG_W-1:0];
				REG_LETHAL:    cfg_q.lethal_value    <= pwdata[CFG_W-1:0];
				REG_MAX_TRACE: cfg_q.max_trace_cells <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		unique case (idx)
			REG_ROW_CELLS: prdata = PDATA_W'(cfg_q.row_cells);
			REG_ROW_COUNT: prdata = PDATA_W'(cfg_q.row_count);
			REG_DEFAULT:   prdata = PDATA_W'(cfg_q.clear_value);
			REG_FREE:      prdata = PDATA_W'(cfg_q.free_value);
			REG_LETHAL:    prdata = PDATA_W'(cfg_q.lethal_value);
			REG_MAX_TRACE: prdata = PDATA_W'(cfg_q.max_trace_cells);
			default:       prdata = '0;
		endcase
	end

endmodule

### rtl/core/ogrc_ctrl.sv
// Command sequencer: steps each request through the datapath and owns the result slot.
module ogrc_ctrl import ogrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CLEAR,
		ST_SETUP_D,
		ST_SETUP_M,
		ST_SETUP_W,
		ST_WALK,
		ST_READ_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign out_valid = out_valid_q;

	// Decode commands and the next state
	always_comb begin
		cmd        = '0;
		cmd.wr_sel = WR_NONE;
		in_ready   = 1'b0;
		state_nxt  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.kind)
					KIND_CLEAR: state_nxt = ST_CLEAR;
					KIND_TRACE: state_nxt = stat.range_ok ? ST_SETUP_D : ST_FINISH;
					KIND_MARK: begin
						if (stat.range_ok) begin
							cmd.wr_sel = WR_LETHAL;
						end
						state_nxt = ST_FINISH;
					end
					KIND_READ: begin
						if (stat.range_ok) begin
							cmd.rd_en = 1'b1;
							state_nxt = ST_READ_WAIT;
						end else begin
							state_nxt = ST_FINISH;
						end
					end
				endcase
			end
			ST_CLEAR: begin
				cmd.wr_sel   = WR_CLEAR;
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_SETUP_D: begin
				cmd.setup_delta = 1'b1;
				state_nxt       = ST_SETUP_M;
			end
			ST_SETUP_M: begin
				cmd.setup_mult = 1'b1;
				state_nxt      = ST_SETUP_W;
			end
			ST_SETUP_W: begin
				cmd.setup_walk = 1'b1;
				state_nxt      = ST_WALK;
			end
			ST_WALK: begin
				cmd.wr_sel = WR_FREE;
				cmd.walk   = 1'b1;
				if (!stat.walk_more) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_READ_WAIT: begin
				cmd.take_read = 1'b1;
				state_nxt     = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Hold state and the result slot flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/ogrc_dp.sv
// Datapath: range checks, line stepper, step limit, clear sweep and the grid store.
module ogrc_dp import ogrc_pkg::*; (
	input  logic               clk,
	input  cfg_t               cfg,
	input  logic [KIND_W-1:0]  kind,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  ctrl_cmd_t          cmd,
	output dp_stat_t           stat,
	output logic [CELL_W-1:0]  read_value,
	output logic               status
);

	function automatic logic in_grid(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [CFG_W-1:0] cols,
			input logic [CFG_W-1:0] rows);
		return (CFG_W'(x) < cols) && (CFG_W'(y) < rows);
	endfunction

	logic [CFG_W-1:0]   used_cols;
	logic [CFG_W-1:0]   used_rows;
	kind_t              in_kind;
	logic               in_ok;

	kind_t              kind_q;
	logic               range_ok_q;
	logic [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [COORD_W-1:0] cur_x_q, cur_y_q;

	logic               x_pos, y_pos;
	logic [COORD_W-1:0] ax, ay;
	logic               x_pos_q, y_pos_q, x_major_q;
	logic [COORD_W-1:0] a_q, b_q;

	logic [SQ_W-1:0]    a2_q, b2_q;
	logic [LA_W-1:0]    la_q;
	logic [D2_W-1:0]    d2;
	logic [D2_W-1:0]    d2_q;
	logic [LIM_W-1:0]   lim_q, prod_q, inc_q;
	logic [COORD_W-1:0] i_q;
	logic [ERR_W-1:0]   err_q;
	logic [ERR_W-1:0]   err_sum;
	logic               minor;
	logic               walk_more;

	logic [ADDR_W-1:0]  clr_cnt_q;
	logic [IDX_W-1:0]   cell_idx;
	logic [ADDR_W-1:0]  ram_addr;
	logic [CELL_W-1:0]  ram_wdata;
	logic [CELL_W-1:0]  ram_rdata;
	logic               ram_we;

	logic [CELL_W-1:0]  res_value_q;
	logic               res_status_q;
	logic [CELL_W-1:0]  out_value_q;
	logic               out_status_q;

	// Clamp the configured grid to the store
	assign used_cols = (cfg.row_cells < COL_CAP) ? cfg.row_cells : COL_CAP;
	assign used_rows = (cfg.row_count < ROW_CAP) ? cfg.row_count : ROW_CAP;

	// Range check of an incoming request
	assign in_kind = kind_t'(kind);
	assign in_ok   = (in_kind == KIND_TRACE)
		? (in_grid(start_x, start_y, used_cols, used_rows)
			&& in_grid(end_x, end_y, used_cols, used_rows))
		: in_grid(start_x, start_y, used_cols, used_rows);

	// Deltas and directions; a zero delta steps negative
	assign x_pos = ex_q > sx_q;
	assign y_pos = ey_q > sy_q;
	assign ax    = x_pos ? (ex_q - sx_q) : (sx_q - ex_q);
	assign ay    = y_pos ? (ey_q - sy_q) : (sy_q - ey_q);

	// Step limit and error terms
	assign d2        = D2_W'(a2_q) + D2_W'(b2_q);
	assign err_sum   = err_q + ERR_W'(b_q);
	assign minor     = err_sum >= ERR_W'(a_q);
	assign walk_more = (i_q < a_q) && (prod_q <= lim_q);

	// Capture the request and run the setup and walk steps
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q       <= in_kind;
			range_ok_q   <= in_ok;
			sx_q         <= start_x;
			sy_q         <= start_y;
			ex_q         <= end_x;
			ey_q         <= end_y;
			cur_x_q      <= start_x;
			cur_y_q      <= start_y;
			clr_cnt_q    <= '0;
			res_value_q  <= '0;
			res_status_q <= (in_kind != KIND_CLEAR) && !in_ok;
		end
		if (cmd.setup_delta) begin
			x_pos_q   <= x_pos;
			y_pos_q   <= y_pos;
			x_major_q <= ax >= ay;
			a_q       <= (ax >= ay) ? ax : ay;
			b_q       <= (ax >= ay) ? ay : ax;
		end
		if (cmd.setup_mult) begin
			a2_q <= SQ_W'(a_q) * SQ_W'(a_q);
			b2_q <= SQ_W'(b_q) * SQ_W'(b_q);
			la_q <= LA_W'(cfg.max_trace_cells) * LA_W'(a_q);
		end
		if (cmd.setup_walk) begin
			d2_q   <= d2;
			lim_q  <= LIM_W'(la_q) * LIM_W'(la_q);
			prod_q <= LIM_W'(d2);
			inc_q  <= LIM_W'(d2) + LIM_W'({d2, 1'b0});
			i_q    <= '0;
			err_q  <= ERR_W'(a_q >> 1);
		end
		// Advance one cell along the line; squares grow by odd multiples of d2
		if (cmd.walk && walk_more) begin
			i_q    <= i_q + 1'b1;
			prod_q <= prod_q + inc_q;
			inc_q  <= inc_q + LIM_W'({d2_q, 1'b0});
			err_q  <= minor ? (err_sum - ERR_W'(a_q)) : err_sum;
			if (x_major_q || minor) begin
				cur_x_q <= x_pos_q ? (cur_x_q + 1'b1) : (cur_x_q - 1'b1);
			end
			if (!x_major_q || minor) begin
				cur_y_q <= y_pos_q ? (cur_y_q + 1'b1) : (cur_y_q - 1'b1);
			end
		end
		if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
		if (cmd.take_read) begin
			res_value_q <= ram_rdata;
		end
		if (cmd.load_out) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	// Select the grid address and write data
	assign cell_idx = IDX_W'(cur_y_q) * IDX_W'(used_cols) + IDX_W'(cur_x_q);
	assign ram_addr = (cmd.wr_sel == WR_CLEAR) ? clr_cnt_q : ADDR_W'(cell_idx);
	assign ram_we   = cmd.wr_sel != WR_NONE;

	always_comb begin
		case (cmd.wr_sel)
			WR_CLEAR:  ram_wdata = cfg.clear_value;
			WR_FREE:   ram_wdata = cfg.free_value;
			WR_LETHAL: ram_wdata = cfg.lethal_value;
			default:   ram_wdata = '0;
		endcase
	end

	ogrc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (GRID_DEPTH)
	) u_grid (
		.clk   (clk),
		.wr_en (ram_we),
		.rd_en (cmd.rd_en),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign stat.kind      = kind_q;
	assign stat.range_ok  = range_ok_q;
	assign stat.walk_more = walk_more;
	assign stat.clr_last  = clr_cnt_q == ADDR_W'(GRID_DEPTH - 1);
	assign read_value     = out_value_q;
	assign status         = out_status_q;

endmodule

### rtl/core/occupancy_grid_ray_clear.sv
// One request at a time; marks and rejects go DISPATCH, FINISH; reads add READ_WAIT.
// Trace: SETUP_D, SETUP_M, SETUP_W, then WALK; one grid write per cycle, single RAM port.
// A clear writes every grid entry in ST_CLEAR, one entry written per cycle.
// The next request is taken the cycle after a result loads, even while that result waits.
// arst_n clears the sequencer and loads register reset values; grid contents stay
// undefined after reset until a clear command has run.
module occupancy_grid_ray_clear import ogrc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	ogrc_cmd_if.sink           cmd,
	ogrc_res_if.source         res
);

	cfg_t      cfg;
	ctrl_cmd_t ctl;
	dp_stat_t  stat;
	logic      in_ready;
	logic      out_valid;
	logic [CELL_W-1:0] read_value;
	logic      status;

	ogrc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ogrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (ctl)
	);

	ogrc_dp u_dp (
		.clk        (clk),
		.cfg        (cfg),
		.kind       (cmd.kind),
		.start_x    (cmd.start_x),
		.start_y    (cmd.start_y),
		.end_x      (cmd.end_x),
		.end_y      (cmd.end_y),
		.cmd        (ctl),
		.stat       (stat),
		.read_value (read_value),
		.status     (status)
	);

	assign cmd.ready      = in_ready;
	assign res.valid      = out_valid;
	assign res.read_value = read_value;
	assign res.status     = status;

endmodule

### rtl/core/ogrc_checker.sv
// Port-level checker for the occupancy grid ray clear block and its bind.
`include "assert_macros.svh"

module ogrc_checker import ogrc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [CELL_W-1:0]  read_value,
	input logic               status,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata
);

	logic [1:0] pend_q;

	// Track requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end

	`ASSERT_CLK(a_reject_reads_zero, clk, arst_n, out_valid && status |-> read_value == '0, "rejected request returned data")
	`ASSERT_CLK(a_result_holds, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status), "stalled result changed")
	`ASSERT_NEVER(a_no_orphan, clk, arst_n, out_valid && pend_q == 2'd0, "result without a pending request")
	`ASSERT_NEVER(a_no_overrun, clk, arst_n, pend_q == 2'd3, "more than two requests in flight")
	`ASSERT_CLK(a_reg_readback, clk, arst_n, psel && penable && pwrite && paddr == '0 |=> !(psel && !pwrite && paddr == '0) || prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]), "row_cells readback mismatch")

endmodule

bind occupancy_grid_ray_clear ogrc_checker u_ogrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd.valid),
	.in_ready   (cmd.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.read_value (res.read_value),
	.status     (res.status),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata)
);
